@@ rtl/fld_pkg.sv @@
package fld_pkg;

  // Field widths
  localparam int unsigned COORD_W  = 16;
  localparam int unsigned COLOUR_W = 32;
  localparam int unsigned SCALE_W  = 5;
  localparam int unsigned SIZE_W   = 9;

  // Scaled coordinate and error term widths
  localparam int unsigned PW = 22;
  localparam int unsigned EW = 25;

  // Default framebuffer bounds
  localparam int unsigned MAX_WIDTH_DEF  = 256;
  localparam int unsigned MAX_HEIGHT_DEF = 256;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = SIZE_W;

  localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  localparam logic [SCALE_W-1:0] SCALE_RST  = 5'd1;
  localparam logic [SIZE_W-1:0]  WIDTH_RST  = 9'd256;
  localparam logic [SIZE_W-1:0]  HEIGHT_RST = 9'd256;

  // Request kinds
  localparam logic KIND_DRAW = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic                       kind;
    logic signed [COORD_W-1:0]  x_start;
    logic signed [COORD_W-1:0]  y_start;
    logic signed [COORD_W-1:0]  x_end;
    logic signed [COORD_W-1:0]  y_end;
    logic        [COLOUR_W-1:0] colour;
  } req_t;

  typedef struct packed {
    logic [COLOUR_W-1:0] pixel_value;
    logic                in_range;
  } rsp_t;

endpackage

@@ rtl/fld_stream_if.sv @@
interface fld_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

@@ rtl/framebuffer_line_drawer_top.sv @@
// Framebuffer line engine.
// req_i (valid/ready) takes one request: a line draw (logical endpoints times
// the scale register, Bresenham walk, pixels outside width x height clipped)
// or a pixel read at a physical address. rsp_o (valid/ready) returns exactly
// one response per request: the pixel and an in-range flag for a read, zero
// and one for a draw. Registers are written through cfg_we_i/cfg_idx_i/
// cfg_data_i; the user must do so only while no request is in flight,
// which the block itself does not enforce.
// A read passes through READ, RDATA and FINISH before it responds. A draw
// passes through SCALE and SETUP, then WALK visits max(|dx|,|dy|)+1 pixels
// (fewer once the line leaves the active area for good), one per cycle as
// bound by the single write port of the pixel memory, then FINISH.
// Reset: the pixel memory is swept to zero, one word per cycle, over all
// MAX_WIDTH*MAX_HEIGHT words (65536 by default); req_i.ready stays low
// meanwhile. Register writes are taken during the sweep.
// Stall: the response sits in an output register; the next request is taken
// while it waits, and its own response is held until the register frees up.
module framebuffer_line_drawer_top #(
  parameter int unsigned MAX_WIDTH  = fld_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = fld_pkg::MAX_HEIGHT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  fld_stream_if.sink                       req_i,
  fld_stream_if.source                     rsp_o,
  input  logic                             cfg_we_i,
  input  logic [fld_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [fld_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned PW       = fld_pkg::PW;
  localparam int unsigned EW       = fld_pkg::EW;
  localparam int unsigned Depth    = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW       = $clog2(Depth);
  localparam int unsigned XW       = $clog2(MAX_WIDTH);
  localparam int unsigned YW       = $clog2(MAX_HEIGHT);
  localparam logic [AW-1:0] LastAddr = AW'(Depth - 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CLEAR  = 3'd1;
  localparam logic [2:0] ST_SCALE  = 3'd2;
  localparam logic [2:0] ST_SETUP  = 3'd3;
  localparam logic [2:0] ST_WALK   = 3'd4;
  localparam logic [2:0] ST_READ   = 3'd5;
  localparam logic [2:0] ST_RDATA  = 3'd6;
  localparam logic [2:0] ST_FINISH = 3'd7;

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] clr_q;

  logic [fld_pkg::SCALE_W-1:0] scale_q;
  logic [fld_pkg::SIZE_W-1:0]  width_q, height_q;

  fld_pkg::req_t item_q;
  fld_pkg::rsp_t rsp_q;
  logic          rsp_valid_q, rsp_valid_d;

  logic signed [PW-1:0] ax_q, ay_q, bx_q, by_q;
  logic signed [EW-1:0] dx_q, dy_q, err_q;
  logic                 sx_pos_q, sy_pos_q, dx_zero_q, dy_zero_q, first_q;

  logic          wr_v_q;
  logic [XW-1:0] wr_x_q;
  logic [YW-1:0] wr_y_q;

  logic                          rd_in_q;
  logic [fld_pkg::COLOUR_W-1:0]  rd_data_q;
  logic [fld_pkg::COLOUR_W-1:0]  res_pix_q;
  logic                          res_rng_q;

  logic [fld_pkg::COLOUR_W-1:0] mem [Depth];

  // Address of pixel (x,y) for the current active width
  function automatic logic [AW-1:0] pix_addr(logic [XW-1:0] x, logic [YW-1:0] y,
                                             logic [fld_pkg::SIZE_W-1:0] w);
    return AW'(AW'(y) * AW'(w)) + AW'(x);
  endfunction

  // Active size, clamped to the memory bounds
  logic [fld_pkg::SIZE_W-1:0] w_act, h_act;
  logic signed [PW-1:0]       w_s, h_s;

  assign w_act = (32'(width_q) < 32'(MAX_WIDTH))   ? width_q  : fld_pkg::SIZE_W'(MAX_WIDTH);
  assign h_act = (32'(height_q) < 32'(MAX_HEIGHT)) ? height_q : fld_pkg::SIZE_W'(MAX_HEIGHT);
  assign w_s   = signed'(PW'(w_act));
  assign h_s   = signed'(PW'(h_act));

  logic req_acc, out_free, load_out;

  assign req_i.ready  = (state_q == ST_IDLE);
  assign req_acc      = req_i.valid && req_i.ready;
  assign out_free     = !rsp_valid_q || rsp_o.ready;
  assign load_out     = (state_q == ST_FINISH) && out_free;
  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

  // Scaling operands
  logic signed [PW-1:0] scale_s, xs_w, ys_w, xe_w, ye_w;

  assign scale_s = signed'(PW'(scale_q));
  assign xs_w    = PW'(item_q.x_start);
  assign ys_w    = PW'(item_q.y_start);
  assign xe_w    = PW'(item_q.x_end);
  assign ye_w    = PW'(item_q.y_end);

  // Line setup: absolute deltas, directions, initial error
  logic                 sx_pos, sy_pos;
  logic signed [PW-1:0] dx_abs, dy_abs;
  logic signed [EW-1:0] dx_e, dy_e;

  assign sx_pos = ax_q < bx_q;
  assign sy_pos = ay_q < by_q;
  assign dx_abs = sx_pos ? (bx_q - ax_q) : (ax_q - bx_q);
  assign dy_abs = sy_pos ? (by_q - ay_q) : (ay_q - by_q);
  assign dx_e   = EW'(dx_abs);
  assign dy_e   = -EW'(dy_abs);

  // Walk step
  logic signed [EW-1:0] e2, err_nx;
  logic                 step_x, step_y, at_end, on_screen, brk, walk_stop;

  assign e2        = err_q <<< 1;
  assign step_x    = e2 >= dy_q;
  assign step_y    = e2 <= dx_q;
  assign err_nx    = err_q + (step_x ? dy_q : EW'(0)) + (step_y ? dx_q : EW'(0));
  assign at_end    = (ax_q == bx_q) && (ay_q == by_q);
  assign on_screen = !ax_q[PW-1] && (ax_q < w_s) && !ay_q[PW-1] && (ay_q < h_s);

  // Line has left the active area and cannot come back
  assign brk = !first_q &&
               ((ax_q[PW-1] && (!sx_pos_q || dx_zero_q)) ||
                ((ax_q >= w_s) && (sx_pos_q || dx_zero_q)) ||
                (ay_q[PW-1] && (!sy_pos_q || dy_zero_q)) ||
                ((ay_q >= h_s) && (sy_pos_q || dy_zero_q)));
  assign walk_stop = brk || at_end;

  // Read address check
  logic    rd_inside;
  logic [AW-1:0] rd_addr;

  assign rd_inside = !item_q.x_start[fld_pkg::COORD_W-1] && (xs_w < w_s) &&
                     !item_q.y_start[fld_pkg::COORD_W-1] && (ys_w < h_s);
  assign rd_addr   = pix_addr(item_q.x_start[XW-1:0], item_q.y_start[YW-1:0], w_act);

  // Memory port control: clear sweep or pixel write
  logic                         mem_we, mem_re;
  logic [AW-1:0]                mem_waddr;
  logic [fld_pkg::COLOUR_W-1:0] mem_wdata;

  assign mem_we    = (state_q == ST_CLEAR) || wr_v_q;
  assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : pix_addr(wr_x_q, wr_y_q, w_act);
  assign mem_wdata = (state_q == ST_CLEAR) ? '0 : item_q.colour;
  assign mem_re    = (state_q == ST_READ);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (clr_q == LastAddr) state_d = ST_IDLE;
      ST_IDLE: begin
        if (req_acc) begin
          state_d = (req_i.payload.kind == fld_pkg::KIND_READ) ? ST_READ : ST_SCALE;
        end
      end
      ST_SCALE:  state_d = ST_SETUP;
      ST_SETUP:  state_d = ST_WALK;
      ST_WALK:   if (walk_stop) state_d = ST_FINISH;
      ST_READ:   state_d = ST_RDATA;
      ST_RDATA:  state_d = ST_FINISH;
      ST_FINISH: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Output register valid
  always_comb begin
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    if (load_out) begin
      rsp_valid_d = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      scale_q     <= fld_pkg::SCALE_RST;
      width_q     <= fld_pkg::WIDTH_RST;
      height_q    <= fld_pkg::HEIGHT_RST;
      first_q     <= 1'b0;
      wr_v_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
      wr_v_q      <= (state_q == ST_WALK) && !brk && on_screen;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (state_q == ST_SETUP) begin
        first_q <= 1'b1;
      end else if (state_q == ST_WALK) begin
        first_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          fld_pkg::CFG_SCALE:  scale_q  <= cfg_data_i[fld_pkg::SCALE_W-1:0];
          fld_pkg::CFG_WIDTH:  width_q  <= cfg_data_i;
          fld_pkg::CFG_HEIGHT: height_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      item_q <= req_i.payload;
    end
    unique case (state_q)
      ST_SCALE: begin
        ax_q <= xs_w * scale_s;
        ay_q <= ys_w * scale_s;
        bx_q <= xe_w * scale_s;
        by_q <= ye_w * scale_s;
      end
      ST_SETUP: begin
        dx_q      <= dx_e;
        dy_q      <= dy_e;
        err_q     <= dx_e + dy_e;
        sx_pos_q  <= sx_pos;
        sy_pos_q  <= sy_pos;
        dx_zero_q <= (ax_q == bx_q);
        dy_zero_q <= (ay_q == by_q);
      end
      ST_WALK: begin
        wr_x_q <= ax_q[XW-1:0];
        wr_y_q <= ay_q[YW-1:0];
        if (walk_stop) begin
          res_pix_q <= '0;
          res_rng_q <= 1'b1;
        end else begin
          err_q <= err_nx;
          if (step_x) ax_q <= sx_pos_q ? ax_q + PW'(1) : ax_q - PW'(1);
          if (step_y) ay_q <= sy_pos_q ? ay_q + PW'(1) : ay_q - PW'(1);
        end
      end
      ST_READ: begin
        rd_in_q <= rd_inside;
      end
      ST_RDATA: begin
        res_pix_q <= rd_in_q ? rd_data_q : '0;
        res_rng_q <= rd_in_q;
      end
      default: ;
    endcase
    if (load_out) begin
      rsp_q.pixel_value <= res_pix_q;
      rsp_q.in_range    <= res_rng_q;
    end
  end

endmodule
